FILE: src/pls_pkg.sv
// pls_pkg: shared types and constants for the positional list store.
// Holds the request/response transaction structs, mode and status codes.
// No dependencies; imported by pls_ctrl and positional_list_store.
package pls_pkg;

    // Storage geometry
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 9;
    localparam int CNT_W    = 9;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
    } rsp_t;

endpackage

FILE: src/pls_ram.sv
// pls_ram: generic simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds while re is low.
// No dependencies.
module pls_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pls_ctrl.sv
// pls_ctrl: request sequencer for the positional list store.
// Decodes each request, runs the read-move-write shift over the entry RAM,
// keeps the entry count and the response register. Uses pls_pkg.
module pls_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  pls_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output pls_pkg::rsp_t                    rsp,
    output logic                             ram_we,
    output logic [pls_pkg::ADDR_W-1:0]       ram_waddr,
    output logic [pls_pkg::DATA_W-1:0]       ram_wdata,
    output logic                             ram_re,
    output logic [pls_pkg::ADDR_W-1:0]       ram_raddr,
    input  logic [pls_pkg::DATA_W-1:0]       ram_rdata
);
    import pls_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_FILL  = 5'b00100,
        S_GETW  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   widx_reg, widx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                ins_reg, ins_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]   rd_reg, rd_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [CNT_W-1:0]    req_pos;

    assign req_pos   = req.position;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer and RAM port control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        widx_next      = widx_reg;
        val_next       = val_reg;
        ins_next       = ins_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = widx_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = widx_reg;

        // response register drains independently of the sequencer
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next    = req_pos[ADDR_W-1:0];
                    val_next    = req.value;
                    ins_next    = (req.mode == MODE_INSERT);
                    status_next = STATUS_DONE;
                    rd_next     = '0;
                    state_next  = S_DONE;
                    unique case (req.mode)
                        MODE_INSERT:
                        begin
                            if (req_pos > count_reg)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else if (req_pos == count_reg)
                            begin
                                // append: single write
                                ram_we     = 1'b1;
                                ram_waddr  = req_pos[ADDR_W-1:0];
                                ram_wdata  = req.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // move entries up, starting at the top
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                                widx_next  = count_reg[ADDR_W-1:0];
                                state_next = S_SHIFT;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (req_pos >= count_reg)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else if (req_pos == count_reg - CNT_W'(1))
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                // move entries down, starting above the hole
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(req_pos + CNT_W'(1));
                                widx_next  = req_pos[ADDR_W-1:0];
                                state_next = S_SHIFT;
                            end
                        end
                        MODE_SET:
                        begin
                            if (req_pos >= count_reg)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = req_pos[ADDR_W-1:0];
                                ram_wdata = req.value;
                            end
                        end
                        MODE_GET:
                        begin
                            if (req_pos >= count_reg)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = req_pos[ADDR_W-1:0];
                                state_next = S_GETW;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // undefined mode: no effect
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // write the word fetched last cycle, fetch the next one
                ram_we    = 1'b1;
                ram_waddr = widx_reg;
                ram_wdata = ram_rdata;
                if (ins_reg)
                begin
                    if (widx_reg == pos_reg + ADDR_W'(1))
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = widx_reg - ADDR_W'(2);
                        widx_next = widx_reg - ADDR_W'(1);
                    end
                end
                else
                begin
                    if (CNT_W'(widx_reg) + CNT_W'(2) == count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = widx_reg + ADDR_W'(2);
                        widx_next = widx_reg + ADDR_W'(1);
                    end
                end
            end

            S_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_GETW:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.read_value  = $signed(rd_reg);
                    rsp_next.status      = status_reg;
                    rsp_next.entry_count = count_reg;
                    rsp_next.is_empty    = (count_reg == '0);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        widx_reg   <= widx_next;
        val_reg    <= val_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        rsp_reg    <= rsp_next;
    end

    // Count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Count moves by one per request, or drops to zero on clear
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == $past(count_reg) + CNT_W'(1)
                                 || count_reg == $past(count_reg) - CNT_W'(1)
                                 || count_reg == '0))
        else $error("entry count jumped");

    // During a shift the read and write never hit the same entry
    a_shift_noalias: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && ram_re) |-> (ram_raddr != ram_waddr))
        else $error("shift read/write address collision");

    // A new response is loaded only on leaving the done state
    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && $past(rsp_valid_reg) && !$stable(rsp_reg))
            |-> ($past(state_reg == S_DONE) && $past(rsp_ready)))
        else $error("response changed without a completed transaction");

endmodule

FILE: src/positional_list_store.sv
// positional_list_store: top level of the bounded ordered list store.
// Instantiates the sequencer (pls_ctrl) and the entry RAM (pls_ram); uses pls_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one request transaction:
//   mode, position, value. rsp channel (rsp_valid/rsp_ready/rsp) returns one
//   response transaction per request: read_value, status, entry_count, is_empty.
//   Requests are handled one at a time; req_ready is high while the sequencer
//   is idle.
// Sequence per request, from accept to rsp_valid:
//   set, clear, errors, append, remove of the last entry: accept, then the done state
//   get: accept with the RAM read, the get-wait state, then the done state
//   insert at p: the shift moves entries p..n-1 up, the fill state writes the value at p
//   remove at p: the shift moves entries p+1..n-1 down, then the done state
//   The shift moves one entry per cycle through the single RAM write port.
// Reset: rst_n clears the entry count and rsp_valid and idles the sequencer; RAM
//   contents are kept, no clearing pass is needed (only entries below count are read).
// Stall: a finished response waits in the output register while the next
//   request is accepted and processed; the sequencer holds before loading a
//   further response until the receiver takes the pending one.
module positional_list_store (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pls_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pls_pkg::rsp_t rsp
);
    import pls_pkg::*;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Request sequencer
    pls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Entry storage
    pls_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
